/* rtl/sdsrx_pkg.sv */
`timescale 1ns / 1ps

package sdsrx_pkg;

	// Input transaction: one message byte or a start-of-dump command
	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic       msg_end;
	} in_item_t;

	// Output transaction: a decoded sample or a packet status
	typedef struct packed {
		logic               kind;
		logic signed [15:0] sample_value;
		logic [2:0]         status;
		logic               last;
	} out_item_t;

	// Commands from the controller to the datapath, at most one per cycle
	typedef struct packed {
		logic take_byte;
		logic start_dump;
		logic latch_status;
		logic rd_en;
		logic load_sample;
		logic load_status;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic drain;
		logic rd_last;
	} dp_sts_t;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_SHORT  = 3'd1;
	localparam logic [2:0] ST_LONG   = 3'd2;
	localparam logic [2:0] ST_CKSUM  = 3'd3;
	localparam logic [2:0] ST_PKTNUM = 3'd4;

	localparam logic [4:0]  SAMPLE_BITS_RST = 5'd16;
	localparam logic [4:0]  SAMPLE_BITS_3G  = 5'd15;
	localparam logic [4:0]  SPAN_2G         = 5'd14;
	localparam logic [4:0]  SPAN_3G         = 5'd21;
	localparam logic [15:0] SAMPLE_OFFSET   = 16'h8000;
	localparam logic [7:0]  PKTNUM_POS      = 8'd4;
	localparam logic [7:0]  PAYLOAD_START   = 8'd5;
	localparam logic [7:0]  POS_MAX         = 8'd255;

endpackage

/* rtl/sdsrx_dp.sv */
`timescale 1ns / 1ps

module sdsrx_dp import sdsrx_pkg::*; #(
	parameter int PAYLOAD_BYTES = 120,
	parameter int PACKET_BYTES  = 127
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [4:0] cfg_wdata,
	input  in_item_t  in_data,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	output out_item_t out_data
);

	localparam int BUF_DEPTH = PAYLOAD_BYTES / 2;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam logic [7:0] CKSUM_POS   = 8'(PACKET_BYTES - 2);
	localparam logic [7:0] PACKET_LEN  = 8'(PACKET_BYTES);
	localparam logic [7:0] PAYLOAD_END = 8'(5 + PAYLOAD_BYTES);

	logic [4:0]       sample_bits_q;
	logic [7:0]       byte_pos_q;
	logic [6:0]       cksum_q;
	logic             cksum_ok_q;
	logic [7:0]       pkt_num_q;
	logic [6:0]       exp_num_q;
	logic [20:0]      acc_q;
	logic [1:0]       grp_q;
	logic [CNT_W-1:0] buf_cnt_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [2:0]       status_q;
	logic [15:0]      rd_data_q;
	out_item_t        out_q;
	logic [15:0]      mem [BUF_DEPTH];

	logic [7:0]  b;
	logic        is_payload;
	logic        groups3;
	logic [20:0] acc_next;
	logic [1:0]  grp_next;
	logic        word_done;
	logic [4:0]  span;
	logic [4:0]  shift;
	logic [20:0] shifted;
	logic [15:0] sample;
	logic        buf_room;
	logic [2:0]  judge;

	assign b          = in_data.rx_byte;
	assign is_payload = (byte_pos_q >= PAYLOAD_START) && (byte_pos_q < PAYLOAD_END) &&
	                    (byte_pos_q < CKSUM_POS);
	assign groups3    = (sample_bits_q >= SAMPLE_BITS_3G);
	assign acc_next   = {acc_q[13:0], b[6:0]};
	assign grp_next   = grp_q + 2'd1;
	assign word_done  = groups3 ? (grp_next == 2'd3) : (grp_next >= 2'd2);
	assign span       = groups3 ? SPAN_3G : SPAN_2G;
	assign shift      = (span > sample_bits_q) ? (span - sample_bits_q) : 5'd0;
	assign shifted    = acc_next >> shift;
	assign sample     = shifted[15:0] - SAMPLE_OFFSET;
	assign buf_room   = (buf_cnt_q < CNT_W'(BUF_DEPTH));

	always_comb begin
		if (byte_pos_q < PACKET_LEN) begin
			judge = ST_SHORT;
		end else if (byte_pos_q > PACKET_LEN) begin
			judge = ST_LONG;
		end else if (!cksum_ok_q) begin
			judge = ST_CKSUM;
		end else if (pkt_num_q != {1'b0, exp_num_q}) begin
			judge = ST_PKTNUM;
		end else begin
			judge = ST_OK;
		end
	end

	assign sts.drain   = (judge == ST_OK) && (buf_cnt_q != '0);
	assign sts.rd_last = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == buf_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bits_q <= SAMPLE_BITS_RST;
		end else if (cfg_we) begin
			sample_bits_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			cksum_q    <= '0;
			cksum_ok_q <= 1'b0;
			pkt_num_q  <= '0;
			acc_q      <= '0;
			grp_q      <= '0;
			buf_cnt_q  <= '0;
			exp_num_q  <= '0;
			rd_idx_q   <= '0;
			status_q   <= ST_OK;
		end else begin
			if (cmd.start_dump || cmd.load_status) begin
				byte_pos_q <= '0;
				cksum_q    <= '0;
				cksum_ok_q <= 1'b0;
				pkt_num_q  <= '0;
				acc_q      <= '0;
				grp_q      <= '0;
				buf_cnt_q  <= '0;
			end else if (cmd.take_byte) begin
				if (byte_pos_q == CKSUM_POS) begin
					cksum_ok_q <= (b == {1'b0, cksum_q});
				end
				if ((byte_pos_q >= 8'd1) && (byte_pos_q < CKSUM_POS)) begin
					cksum_q <= cksum_q ^ b[6:0];
				end
				if (byte_pos_q == PKTNUM_POS) begin
					pkt_num_q <= b;
				end
				if (is_payload) begin
					if (word_done) begin
						acc_q <= '0;
						grp_q <= '0;
						if (buf_room) begin
							buf_cnt_q <= buf_cnt_q + CNT_W'(1);
						end
					end else begin
						acc_q <= acc_next;
						grp_q <= grp_next;
					end
				end
				if (byte_pos_q != POS_MAX) begin
					byte_pos_q <= byte_pos_q + 8'd1;
				end
			end

			if (cmd.start_dump) begin
				exp_num_q <= '0;
			end else if (cmd.load_status && (status_q == ST_OK)) begin
				exp_num_q <= exp_num_q + 7'd1;
			end

			if (cmd.latch_status) begin
				status_q <= judge;
				rd_idx_q <= '0;
			end else if (cmd.load_sample) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
		end
	end

	// sample buffer: one write port on the byte side, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.take_byte && is_payload && word_done && buf_room) begin
			mem[buf_cnt_q[IDX_W-1:0]] <= sample;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			out_q.kind         <= KIND_SAMPLE;
			out_q.sample_value <= rd_data_q;
			out_q.status       <= ST_OK;
			out_q.last         <= 1'b0;
		end else if (cmd.load_status) begin
			out_q.kind         <= KIND_STATUS;
			out_q.sample_value <= '0;
			out_q.status       <= status_q;
			out_q.last         <= 1'b1;
		end
	end

	assign out_data = out_q;

endmodule

/* rtl/sdsrx_ctrl.sv */
`timescale 1ns / 1ps

module sdsrx_ctrl import sdsrx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    in_cmd,
	input  logic    in_msg_end,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_JUDGE = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_SMP   = 3'd3;
	localparam logic [2:0] S_STAT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_START) begin
						cmd.start_dump = 1'b1;
					end else begin
						cmd.take_byte = 1'b1;
						if (in_msg_end) begin
							state_d = S_JUDGE;
						end
					end
				end
			end
			S_JUDGE: begin
				cmd.latch_status = 1'b1;
				state_d = sts.drain ? S_RD : S_STAT;
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SMP;
			end
			S_SMP: begin
				if (slot_free) begin
					cmd.load_sample = 1'b1;
					state_d = sts.rd_last ? S_STAT : S_RD;
				end
			end
			S_STAT: begin
				if (slot_free) begin
					cmd.load_status = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_sample || cmd.load_status) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/sds_data_packet_receiver.sv */
`timescale 1ns / 1ps

// Channel   Handshake              Payload      Transaction
// cfg       cfg_we                 cfg_wdata    sample_bits write, no wait
// in        in_valid / in_ready    in_data      one message byte or start command
// out       out_valid / out_ready  out_data     one sample or one packet status
//
// A byte that is not a message's final byte is accepted while idle; a start
// command too. A final byte is judged; for a good packet each buffered sample
// is then read from the buffer and loaded into the output register, and the
// status is loaded last. A failed packet goes from judging straight to its
// status, and out_ready can hold off each load. The drain does not overlap a
// buffer read with the previous output load.
// Reset (arst_n low) clears the controller, message state and expected number.
// in_ready is low from a final byte until its status is loaded into the output
// register; the next byte is taken while that status still waits for out_ready.

module sds_data_packet_receiver import sdsrx_pkg::*; #(
	parameter int PAYLOAD_BYTES = 120,
	parameter int PACKET_BYTES  = 127
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// Controller: sequences byte intake, judging, buffer drain and status
	sdsrx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_cmd     (in_data.cmd),
		.in_msg_end (in_data.msg_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sts        (dp_sts),
		.cmd        (dp_cmd)
	);

	// Datapath: position, checksum, word unpacking, sample buffer, output register
	sdsrx_dp #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.PACKET_BYTES  (PACKET_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// never issue two datapath commands in one cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(dp_cmd))
		else $error("more than one datapath command");

	// load the output register only when it is empty or being drained
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.load_sample || dp_cmd.load_status) |-> (!out_valid || out_ready))
		else $error("output register overwritten");

	// a status transaction closes the item and a sample never does
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.kind == KIND_STATUS)))
		else $error("last flag does not match result kind");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

// Sample dump data packet receiver testbench. A scoreboard class decodes every
// accepted byte the way the receiver should, queues the samples and the packet
// status that the byte must produce, and checks each output transaction against
// the oldest queued one. Stimulus is a few directed short messages, then one
// well-formed 127-byte packet with random content at a random resolution, sent
// while the receiver holds off, followed by short and aborted messages.

module tb_top import sdsrx_pkg::*;;

	localparam int PKT_LEN     = 127;
	localparam int PAYLOAD_LEN = 120;
	localparam int CKSUM_POS   = PKT_LEN - 2;
	localparam int BUF_WORDS   = PAYLOAD_LEN / 2;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE      = 8;
	localparam int SHORT_MAX   = 8;

	typedef enum {
		PK_GOOD, PK_SHORT, PK_ABORT
	} pkt_kind_e;

	// Decodes accepted bytes into the samples and statuses they must cause,
	// then matches output transactions against them in order.
	class sds_decoder_sb;
		logic [4:0]  res_bits;
		logic [7:0]  pos;
		logic [6:0]  xsum;
		logic [7:0]  rx_num;
		logic [6:0]  want_num;
		logic [20:0] acc;
		int unsigned groups_in;
		logic [15:0] words [BUF_WORDS];
		int unsigned n_words;
		bit          xsum_ok;
		int unsigned mismatches;
		out_item_t   decode_queue [$];

		function new();
			res_bits   = SAMPLE_BITS_RST;
			want_num   = '0;
			mismatches = 0;
			clear_msg();
		endfunction

		function void clear_msg();
			pos       = '0;
			xsum      = '0;
			rx_num    = '0;
			acc       = '0;
			groups_in = 0;
			n_words   = 0;
			xsum_ok   = 1'b0;
		endfunction

		function void set_bits(logic [4:0] v);
			res_bits = v;
		endfunction

		function int pending();
			return decode_queue.size();
		endfunction

		// Shift one 7-bit group in; finish a word once all its groups are in.
		function void push_group(logic [7:0] b);
			int unsigned groups;
			int unsigned span;
			int unsigned shift;
			logic [20:0] value;
			groups = (res_bits < SAMPLE_BITS_3G) ? 2 : 3;
			span   = (groups == 2) ? SPAN_2G : SPAN_3G;
			acc    = {acc[13:0], b[6:0]};
			groups_in++;
			if (groups_in < groups)
				return;
			shift = (span > res_bits) ? span - res_bits : 0;
			value = acc >> shift;
			if (n_words < BUF_WORDS) begin
				words[n_words] = value[15:0] - SAMPLE_OFFSET;
				n_words++;
			end
			acc       = '0;
			groups_in = 0;
		endfunction

		function void decode_byte(in_item_t it);
			logic [7:0] p;
			logic [2:0] verdict;
			out_item_t  r;
			if (it.cmd == CMD_START) begin
				clear_msg();
				want_num = '0;
				return;
			end
			p = pos;
			if (p == CKSUM_POS)
				xsum_ok = (it.rx_byte == {1'b0, xsum});
			if (p >= 1 && p < CKSUM_POS)
				xsum = xsum ^ it.rx_byte[6:0];
			if (p == PKTNUM_POS)
				rx_num = it.rx_byte;
			if (p >= PAYLOAD_START && p < PAYLOAD_START + PAYLOAD_LEN && p < CKSUM_POS)
				push_group(it.rx_byte);
			if (pos != POS_MAX)
				pos++;
			if (!it.msg_end)
				return;

			if (pos < PKT_LEN)
				verdict = ST_SHORT;
			else if (pos > PKT_LEN)
				verdict = ST_LONG;
			else if (!xsum_ok)
				verdict = ST_CKSUM;
			else if (rx_num != {1'b0, want_num})
				verdict = ST_PKTNUM;
			else
				verdict = ST_OK;

			if (verdict == ST_OK) begin
				for (int i = 0; i < n_words; i++) begin
					r.kind         = KIND_SAMPLE;
					r.sample_value = words[i];
					r.status       = ST_OK;
					r.last         = 1'b0;
					decode_queue.push_back(r);
				end
				want_num++;
			end
			r.kind         = KIND_STATUS;
			r.sample_value = '0;
			r.status       = verdict;
			r.last         = 1'b1;
			decode_queue.push_back(r);
			clear_msg();
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (decode_queue.size() == 0) begin
				$error("unexpected result: kind %0d sample %0d status %0d last %0d",
					got.kind, got.sample_value, got.status, got.last);
				mismatches++;
				return;
			end
			want = decode_queue.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				mismatches++;
			end
			if (got.sample_value !== want.sample_value) begin
				$error("sample_value: expected %0d, got %0d",
					want.sample_value, got.sample_value);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [4:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;

	// Idling controls that the stimulus sets for the sender and the receiver processes
	bit calm_tx;
	bit calm_rx;
	bit hold_req;

	sds_decoder_sb sb = new();

	sds_data_packet_receiver #(
		.PAYLOAD_BYTES(PAYLOAD_LEN),
		.PACKET_BYTES (PKT_LEN)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	// Both monitors sample the values from before the edge, so the order in
	// which processes wake within the step does not matter.
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.decode_byte(in_data);
		if (out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Receiver: drop ready at random, 13 percent of the time, never while calm_rx
	// is set, and hold off for a long stretch when asked so the input backs up.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm_rx || ($urandom_range(99) >= 13);
			@(posedge clk);
		end
	end

	// Offer one transaction and hold it until accepted. Valid is left high so
	// that a back-to-back transaction can follow without a gap.
	task automatic send_item(input logic op, input logic [7:0] byte_val, input logic fin);
		if (!calm_tx && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_data  <= '{cmd: op, rx_byte: byte_val, msg_end: fin};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_start();
		send_item(CMD_START, 8'($urandom), 1'($urandom));
	endtask

	// Stop offering, let the monitor decode the last accepted byte, let every
	// queued result drain, then let the block settle.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_bits(input logic [4:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_bits(v);
	endtask

	// Build each byte as it is sent; the packet number is read from the
	// scoreboard at byte 4, long after the previous packet was decoded.
	task automatic send_packet(input pkt_kind_e kind);
		int         len;
		int         fill;
		logic [7:0] b;
		logic [6:0] x;
		if (kind == PK_GOOD)
			len = PKT_LEN;
		else
			len = $urandom_range(1, SHORT_MAX);
		fill = $urandom_range(7);
		x    = '0;
		for (int p = 0; p < len; p++) begin
			b = 8'($urandom);
			if (p >= PAYLOAD_START && p < CKSUM_POS) begin
				// Occasionally flat payloads hit the sample extremes
				if (fill == 0)
					b = {b[7], 7'h00};
				else if (fill == 1)
					b = {b[7], 7'h7F};
			end
			if (p == PKTNUM_POS && (kind == PK_GOOD || $urandom_range(1)))
				b = {1'b0, sb.want_num};
			if (p == CKSUM_POS)
				b = {1'b0, x};
			if (p >= 1 && p < CKSUM_POS)
				x = x ^ b[6:0];
			send_item(CMD_BYTE, b, kind != PK_ABORT && p == len - 1);
		end
		if (kind == PK_ABORT)
			send_start();
	endtask

	initial begin
		logic [4:0] bit_steps [6];
		bit_steps = '{5'd9, 5'd14, 5'd15, 5'd16, 5'd10, 5'd13};
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = SAMPLE_BITS_RST;
		in_valid  = 1'b0;
		in_data   = '0;
		calm_tx   = 1'b0;
		calm_rx   = 1'b0;
		hold_req  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: start commands with ignored fields, short messages of one
		// and several bytes, and a message cut off by a start command.
		send_item(CMD_START, 8'hFF, 1'b1);
		send_item(CMD_BYTE, 8'h00, 1'b1);
		send_item(CMD_BYTE, 8'hFF, 1'b0);
		send_item(CMD_BYTE, 8'h7F, 1'b0);
		send_item(CMD_BYTE, 8'h80, 1'b1);
		send_item(CMD_START, 8'h00, 1'b0);
		for (int i = 0; i < 6; i++)
			send_item(CMD_BYTE, (i == PKTNUM_POS) ? 8'h00 : 8'hF0 + 8'(i), i == 5);
		send_item(CMD_BYTE, 8'hFF, 1'b0);
		send_item(CMD_BYTE, 8'h55, 1'b0);
		send_item(CMD_START, 8'hAA, 1'b1);
		send_item(CMD_BYTE, 8'h01, 1'b1);

		// One full packet at a random resolution, sent with no idling while the
		// receiver holds off: the drain stalls and the short messages behind it
		// back up at the input. The register is written only with nothing in
		// flight.
		quiesce();
		write_bits(bit_steps[$urandom_range(5)]);
		calm_tx  = 1'b1;
		calm_rx  = 1'b1;
		hold_req = 1'b1;
		send_packet(PK_GOOD);
		for (int i = 0; i < 4; i++)
			send_packet(PK_SHORT);
		send_packet(PK_ABORT);
		calm_tx = 1'b0;
		calm_rx = 1'b0;

		// A few short messages at a resolution drawn anew
		quiesce();
		write_bits(bit_steps[$urandom_range(5)]);
		for (int i = 0; i < 3; i++)
			send_packet(PK_SHORT);

		quiesce();
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
